/* rtl/mmc_cds_pkg.sv */
// Shared constants for the card clock divider solver.
package mmc_cds_pkg;

	localparam int unsigned MAX_LINEAR_DIV   = 16;
	localparam int unsigned MAX_PRE_DIV_LOG2 = 3;

	localparam int unsigned REQ_W   = 32;
	localparam int unsigned PRE_W   = 2;
	localparam int unsigned M_OUT_W = 5;
	localparam int unsigned DLY_W   = 3;
	localparam int unsigned STAT_W  = 2;

	localparam int unsigned DIV_STEPS = REQ_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [REQ_W-1:0] OSC_HZ       = 32'd24000000;
	localparam logic [REQ_W-1:0] BAND_SLOW_HZ = 32'd400000;
	localparam logic [REQ_W-1:0] BAND_STD_HZ  = 32'd25000000;
	localparam logic [REQ_W-1:0] BAND_HIGH_HZ = 32'd52000000;
	localparam logic [REQ_W-1:0] PLL_RESET_HZ = 32'd600000000;

	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNAVAILABLE = 2'd2;

	localparam logic [DLY_W-1:0] OCLK_SLOW = 3'd0;
	localparam logic [DLY_W-1:0] SCLK_SLOW = 3'd0;
	localparam logic [DLY_W-1:0] OCLK_STD  = 3'd0;
	localparam logic [DLY_W-1:0] SCLK_STD  = 3'd5;
	localparam logic [DLY_W-1:0] OCLK_HIGH = 3'd3;
	localparam logic [DLY_W-1:0] SCLK_HIGH = 3'd4;
	localparam logic [DLY_W-1:0] OCLK_FAST = 3'd1;
	localparam logic [DLY_W-1:0] SCLK_FAST = 3'd4;

endpackage

/* rtl/mmc_clock_divider_solve_top.sv */
// Card clock divider solver: serial divide, then halving steps for the pre divider.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall | requested_hz
//  out     | from block| out_valid/ out_stall| clock_enable .. status (seven fields)
//  cfg     | to block  | cfg_wr_en           | cfg_wr_data -> pll_source_hz
//
// Each item is accepted, then runs the restoring divider (one quotient bit a cycle),
// a ceiling step, up to three halvings and a final check, and a load of the output
// register, which waits while out_stall holds a result. Disable and missing-source
// items go from accept straight to the output register load.
// Reset clears control state and sets pll_source_hz to 600 MHz.
// A new item is taken while a finished result waits on out_stall; the sequencer
// holds in its final state until the output register is free.
module mmc_clock_divider_solve_top
	import mmc_cds_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_wr_en,
	input  logic [REQ_W-1:0]    cfg_wr_data,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    requested_hz,

	output logic                out_valid,
	input  logic                out_stall,
	output logic                clock_enable,
	output logic                source_select,
	output logic [PRE_W-1:0]    pre_div_log2,
	output logic [M_OUT_W-1:0]  divide_m,
	output logic [DLY_W-1:0]    out_clock_delay,
	output logic [DLY_W-1:0]    sample_clock_delay,
	output logic [STAT_W-1:0]   status
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_CEIL  = 3'd2;
	localparam logic [2:0] S_HALVE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam int unsigned M_W = REQ_W + 1;

	logic [2:0]         state_q;
	logic [REQ_W-1:0]   pll_q;
	logic [REQ_W-1:0]   req_q;
	logic [REQ_W-1:0]   quo_q;
	logic [REQ_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [M_W-1:0]     m_q;
	logic [PRE_W-1:0]   n_q;
	logic               en_q;
	logic               sel_q;
	logic [DLY_W-1:0]   oclk_q;
	logic [DLY_W-1:0]   sclk_q;
	logic [STAT_W-1:0]  stat_q;

	logic               out_valid_q;
	logic               res_en_q;
	logic               res_sel_q;
	logic [PRE_W-1:0]   res_n_q;
	logic [M_OUT_W-1:0] res_m_q;
	logic [DLY_W-1:0]   res_oclk_q;
	logic [DLY_W-1:0]   res_sclk_q;
	logic [STAT_W-1:0]  res_stat_q;

	logic               accept;
	logic               use_pll;
	logic [REQ_W:0]     shifted;
	logic [REQ_W:0]     diff;
	logic               take;
	logic [REQ_W-1:0]   rem_next;
	logic               m_big;
	logic               can_halve;
	logic               out_free;
	logic               res_ok;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign use_pll   = (requested_hz > OSC_HZ);

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign shifted   = {rem_q, quo_q[REQ_W-1]};
	assign diff      = shifted - {1'b0, req_q};
	assign take      = !diff[REQ_W];
	assign rem_next  = take ? diff[REQ_W-1:0] : shifted[REQ_W-1:0];

	assign m_big     = (m_q > M_W'(MAX_LINEAR_DIV));
	assign can_halve = (n_q < PRE_W'(MAX_PRE_DIV_LOG2));
	assign out_free  = !out_valid_q || !out_stall;
	assign res_ok    = en_q && (stat_q == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll_q <= PLL_RESET_HZ;
		end else if (cfg_wr_en) begin
			pll_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						n_q   <= '0;
						if (requested_hz == '0) begin
							state_q <= S_FIN;
						end else if (use_pll && pll_q == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_CEIL;
					end
				end
				S_CEIL: begin
					state_q <= S_HALVE;
				end
				S_HALVE: begin
					if (m_big && can_halve) begin
						n_q <= n_q + 1'b1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q <= requested_hz;
					quo_q <= use_pll ? pll_q : OSC_HZ;
					rem_q <= '0;
					sel_q <= use_pll;
					en_q  <= (requested_hz != '0);
					if (use_pll && pll_q == '0) begin
						stat_q <= ST_UNAVAILABLE;
					end else begin
						stat_q <= ST_OK;
					end
					if (requested_hz <= BAND_SLOW_HZ) begin
						oclk_q <= OCLK_SLOW;
						sclk_q <= SCLK_SLOW;
					end else if (requested_hz <= BAND_STD_HZ) begin
						oclk_q <= OCLK_STD;
						sclk_q <= SCLK_STD;
					end else if (requested_hz <= BAND_HIGH_HZ) begin
						oclk_q <= OCLK_HIGH;
						sclk_q <= SCLK_HIGH;
					end else begin
						oclk_q <= OCLK_FAST;
						sclk_q <= SCLK_FAST;
					end
				end
			end
			S_DIV: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[REQ_W-2:0], take};
			end
			S_CEIL: begin
				// round the quotient up when anything is left over
				m_q <= {1'b0, quo_q} + M_W'(rem_q != '0);
			end
			S_HALVE: begin
				if (m_big && can_halve) begin
					m_q <= M_W'((m_q + 1'b1) >> 1);
				end else if (m_big) begin
					stat_q <= ST_UNSUPPORTED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			res_en_q   <= res_ok;
			res_sel_q  <= res_ok ? sel_q : 1'b0;
			res_n_q    <= res_ok ? n_q : '0;
			res_m_q    <= res_ok ? m_q[M_OUT_W-1:0] : '0;
			res_oclk_q <= res_ok ? oclk_q : '0;
			res_sclk_q <= res_ok ? sclk_q : '0;
			res_stat_q <= en_q ? stat_q : ST_OK;
		end
	end

	assign out_valid          = out_valid_q;
	assign clock_enable       = res_en_q;
	assign source_select      = res_sel_q;
	assign pre_div_log2       = res_n_q;
	assign divide_m           = res_m_q;
	assign out_clock_delay    = res_oclk_q;
	assign sample_clock_delay = res_sclk_q;
	assign status             = res_stat_q;

endmodule

/* bench/mmc_clock_divider_solve_top_tb.sv */
// Self-checking testbench for the card clock divider solver, with random idling on both channels.
`timescale 1ns / 100ps

module mmc_clock_divider_solve_top_tb
	import mmc_cds_pkg::*;
();

	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned RAND_PER_SETTING = 100;

	typedef struct packed {
		logic                clock_enable;
		logic                source_select;
		logic [PRE_W-1:0]    pre_div_log2;
		logic [M_OUT_W-1:0]  divide_m;
		logic [DLY_W-1:0]    out_clock_delay;
		logic [DLY_W-1:0]    sample_clock_delay;
		logic [STAT_W-1:0]   status;
	} clk_setting_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [REQ_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [REQ_W-1:0]    requested_hz = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                clock_enable;
	logic                source_select;
	logic [PRE_W-1:0]    pre_div_log2;
	logic [M_OUT_W-1:0]  divide_m;
	logic [DLY_W-1:0]    out_clock_delay;
	logic [DLY_W-1:0]    sample_clock_delay;
	logic [STAT_W-1:0]   status;

	logic [REQ_W-1:0]    pending_reqs[$];
	clk_setting_t        expected_settings[$];
	logic [REQ_W-1:0]    pll_hz_model = PLL_RESET_HZ;
	clk_setting_t        seen_setting;
	bit                  calm = 1'b0;
	int unsigned         req_gap = 0;
	int unsigned         stall_left = 0;
	int unsigned         failures = 0;
	int unsigned         results_checked = 0;
	int unsigned         pll_settings = 1;
	int unsigned         n_ok = 0;
	int unsigned         n_off = 0;
	int unsigned         n_unsup = 0;
	int unsigned         n_nosrc = 0;

	mmc_clock_divider_solve_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.requested_hz       (requested_hz),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.clock_enable       (clock_enable),
		.source_select      (source_select),
		.pre_div_log2       (pre_div_log2),
		.divide_m           (divide_m),
		.out_clock_delay    (out_clock_delay),
		.sample_clock_delay (sample_clock_delay),
		.status             (status)
	);

	assign seen_setting = {clock_enable, source_select, pre_div_log2, divide_m,
		out_clock_delay, sample_clock_delay, status};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic clk_setting_t solve_divider(input logic [REQ_W-1:0] req,
		input logic [REQ_W-1:0] pll_hz);
		clk_setting_t r;
		logic [63:0]  src;
		logic [63:0]  m;
		int unsigned  n;
		r = '0;
		n = 0;
		if (req == '0)
			return r;
		if (req <= OSC_HZ) begin
			src = {32'd0, OSC_HZ};
		end else begin
			if (pll_hz == '0) begin
				r.status = ST_UNAVAILABLE;
				return r;
			end
			src = {32'd0, pll_hz};
		end
		m = (src + {32'd0, req} - 64'd1) / {32'd0, req};
		if (m == 64'd0)
			m = 64'd1;
		// halve until m fits the linear divider
		while (m > MAX_LINEAR_DIV) begin
			n++;
			m = (m + 64'd1) / 64'd2;
		end
		if (n > MAX_PRE_DIV_LOG2) begin
			r.status = ST_UNSUPPORTED;
			return r;
		end
		if (req <= BAND_SLOW_HZ) begin
			r.out_clock_delay = OCLK_SLOW;
			r.sample_clock_delay = SCLK_SLOW;
		end else if (req <= BAND_STD_HZ) begin
			r.out_clock_delay = OCLK_STD;
			r.sample_clock_delay = SCLK_STD;
		end else if (req <= BAND_HIGH_HZ) begin
			r.out_clock_delay = OCLK_HIGH;
			r.sample_clock_delay = SCLK_HIGH;
		end else begin
			r.out_clock_delay = OCLK_FAST;
			r.sample_clock_delay = SCLK_FAST;
		end
		r.clock_enable = 1'b1;
		r.source_select = (req > OSC_HZ);
		r.pre_div_log2 = n[PRE_W-1:0];
		r.divide_m = m[M_OUT_W-1:0];
		r.status = ST_OK;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic string fmt_setting(input clk_setting_t s);
		return $sformatf("en=%0d sel=%0d n=%0d m=%0d oclk=%0d sclk=%0d st=%0d",
			s.clock_enable, s.source_select, s.pre_div_log2, s.divide_m,
			s.out_clock_delay, s.sample_clock_delay, s.status);
	endfunction

	function automatic logic [REQ_W-1:0] pick_request();
		logic [REQ_W-1:0] edges[8];
		logic [REQ_W-1:0] base;
		edges = '{BAND_SLOW_HZ, OSC_HZ, BAND_STD_HZ, BAND_HIGH_HZ,
			32'd187500, 32'd1500000, 32'hFFFFFFFF, 32'd1};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(1, BAND_SLOW_HZ);
			2, 3: return $urandom_range(BAND_SLOW_HZ + 1, OSC_HZ);
			4: begin
				// land near exact divisions of the oscillator
				base = OSC_HZ / $urandom_range(1, 200);
				return base + $urandom_range(0, 2) - 1;
			end
			5, 6: return $urandom_range(OSC_HZ + 1, 32'd200000000);
			7: return $urandom();
			8: begin
				base = edges[$urandom_range(0, 7)];
				return base + $urandom_range(0, 2) - 1;
			end
			default: begin
				base = pll_hz_model / $urandom_range(1, 200);
				return base + $urandom_range(0, 2) - 1;
			end
		endcase
	endfunction

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_settings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pll(input logic [REQ_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		pll_hz_model = v;
		pll_settings++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin
		clk_setting_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = solve_divider(requested_hz, pll_hz_model);
				expected_settings.push_back(want);
				if (!want.clock_enable) begin
					case (want.status)
						ST_UNSUPPORTED: n_unsup++;
						ST_UNAVAILABLE: n_nosrc++;
						default: n_off++;
					endcase
				end else begin
					n_ok++;
				end
			end
			if (!in_valid || !in_stall) begin
				if (req_gap > 0) begin
					in_valid <= 1'b0;
					req_gap <= req_gap - 1;
				end else if (pending_reqs.size() != 0) begin
					in_valid <= 1'b1;
					requested_hz <= pending_reqs.pop_front();
					req_gap <= idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		clk_setting_t want;
		int unsigned g;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_settings.size() == 0) begin
					log_failure($sformatf("unexpected item %s", fmt_setting(seen_setting)));
				end else begin
					want = expected_settings.pop_front();
					if (seen_setting !== want)
						log_failure($sformatf("expected %s got %s",
							fmt_setting(want), fmt_setting(seen_setting)));
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				g = idle_len();
				out_stall <= (g > 0);
				stall_left <= (g > 0) ? g - 1 : 0;
			end
		end
	end

	initial begin
		logic [REQ_W-1:0] pll_plan[8];
		pll_plan = '{32'd0, 32'hFFFFFFFF, 32'd1, BAND_HIGH_HZ, 32'd400000000,
			PLL_RESET_HZ, $urandom(), $urandom_range(OSC_HZ, 32'd1200000000)};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// band edges, oscillator and divider limits, at the reset source value
		pending_reqs = '{32'd0, 32'd1, BAND_SLOW_HZ, BAND_SLOW_HZ + 1, OSC_HZ, OSC_HZ + 1,
			BAND_STD_HZ, BAND_STD_HZ + 1, BAND_HIGH_HZ, BAND_HIGH_HZ + 1, 32'hFFFFFFFF,
			32'd1500000, 32'd1499999, 32'd187500, 32'd187499, 32'd600000000,
			32'd600000001, 32'd37500000, 32'd37499999, 32'd4687500, 32'h80000000,
			32'h55555555, 32'h2AAAAAAA};
		wait_idle();

		foreach (pll_plan[i]) begin
			write_pll(pll_plan[i]);
			calm = (i == 3);
			repeat (RAND_PER_SETTING) pending_reqs.push_back(pick_request());
			wait_idle();
		end

		$display("checked %0d results over %0d source settings", results_checked, pll_settings);
		$display("  %0d configured, %0d disabled, %0d unsupported, %0d source missing",
			n_ok, n_off, n_unsup, n_nosrc);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", failures);
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#15ms;
		$display("timeout at %0t", $realtime);
		$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/mmc_cds_pkg.sv
rtl/mmc_clock_divider_solve_top.sv
bench/mmc_clock_divider_solve_top_tb.sv
